FILE: src/egv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egv_pkg
// shared constants and types of the elliptical gaussian visibility pipeline
// ----------------------------------------------------------------------------
package egv_pkg;

   // ln 2 in q.32, used to build the exp2 table
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   // log2(e) in q.30
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   // exponent limit: 400.0 in q16.16
   localparam logic [29:0] EXPO_LIMIT = 30'd26214400;
   // pipeline depth from item accept to result strobe
   localparam int LATENCY = 18;

   // register map of the csr port
   typedef enum logic [2:0] {
      CSR_FLUX_PARAM      = 3'd0,
      CSR_WIDTH_ALPHA     = 3'd1,
      CSR_WIDTH_BETA      = 3'd2,
      CSR_COS_ANGLE       = 3'd3,
      CSR_SIN_ANGLE       = 3'd4,
      CSR_SIZE_GAIN       = 3'd5,
      CSR_ASYM_PLUS_GAIN  = 3'd6,
      CSR_ASYM_MINUS_GAIN = 3'd7
   } csr_index_type;

   // rotated baseline: magnitudes and the product of the two signs
   typedef struct packed {
      logic [49:0] mag_u;
      logic [49:0] mag_v;
      logic        sign_x;
   } rot_type;

endpackage

FILE: src/elliptical_gaussian_visibility_grad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptical_gaussian_visibility_grad
// real visibility of an elliptical gaussian and its parameter derivatives
//
//  channel  ports                                   handshake
//  request  req_baseline_u, req_baseline_v          start && !busy
//  result   rsp_vis_real, rsp_d_flux, rsp_d_size,   rsp_strobe, one cycle
//           rsp_d_asym, rsp_d_angle
//  csr      csr_index, csr_write_data               csr_write_en
//
// one item is taken every cycle while busy is low; each result strobes once
// its item has passed the pipeline depth of the chained multipliers and the
// exp2 table path. busy is high only during reset. the exp2 table is built
// at elaboration, so no fill pass follows reset. results cannot be held off:
// the strobe marks the single cycle in which a result is valid
// ----------------------------------------------------------------------------
module elliptical_gaussian_visibility_grad
   import egv_pkg::*;
#(
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_baseline_u,
   input  logic signed [31:0] req_baseline_v,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_vis_real,
   output logic signed [31:0] rsp_d_flux,
   output logic signed [31:0] rsp_d_size,
   output logic signed [31:0] rsp_d_asym,
   output logic signed [31:0] rsp_d_angle,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   // saturating sign-and-magnitude to int32
   function automatic logic [31:0] pack_q(input logic neg, input logic [40:0] m);
      logic [40:0] lim;
      lim = (m > 41'h80000000) ? 41'h80000000 : m;
      if (neg) begin
         pack_q = 32'(-lim);
      end else begin
         pack_q = (m > 41'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
      end
   endfunction

   logic signed [31:0] flux_param_ff, cos_angle_ff, sin_angle_ff, size_gain_ff;
   logic [31:0]        width_alpha_ff, width_beta_ff;
   logic [31:0]        asym_plus_gain_ff, asym_minus_gain_ff;
   logic [LATENCY-1:0] vld_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         flux_param_ff      <= 32'sd65536;
         width_alpha_ff     <= '0;
         width_beta_ff      <= '0;
         cos_angle_ff       <= 32'sd1073741824;
         sin_angle_ff       <= '0;
         size_gain_ff       <= '0;
         asym_plus_gain_ff  <= '0;
         asym_minus_gain_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FLUX_PARAM:      flux_param_ff      <= $signed(csr_write_data);
            CSR_WIDTH_ALPHA:     width_alpha_ff     <= csr_write_data;
            CSR_WIDTH_BETA:      width_beta_ff      <= csr_write_data;
            CSR_COS_ANGLE:       cos_angle_ff       <= $signed(csr_write_data);
            CSR_SIN_ANGLE:       sin_angle_ff       <= $signed(csr_write_data);
            CSR_SIZE_GAIN:       size_gain_ff       <= $signed(csr_write_data);
            CSR_ASYM_PLUS_GAIN:  asym_plus_gain_ff  <= csr_write_data;
            CSR_ASYM_MINUS_GAIN: asym_minus_gain_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // item valid travels with the data
   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], start && !busy};
      end
   end

   // rotation
   rot_type rot;

   egv_rotate u_rot (
      .clock (clock),
      .u     (req_baseline_u),
      .v     (req_baseline_v),
      .c     (cos_angle_ff),
      .s     (sin_angle_ff),
      .rot   (rot)
   );

   // scaled axes a, b and cross terms
   logic [22:0] a4, b4;
   logic [34:0] c1_4, c2_4;

   egv_mulsat #(.XW(50), .YW(32), .SH(30), .CAPW(22)) u_mul_a (
      .clock(clock), .x(rot.mag_u), .y(width_alpha_ff), .p(a4));
   egv_mulsat #(.XW(50), .YW(32), .SH(30), .CAPW(22)) u_mul_b (
      .clock(clock), .x(rot.mag_v), .y(width_beta_ff), .p(b4));
   egv_mulsat #(.XW(50), .YW(32), .SH(30), .CAPW(34)) u_mul_c1 (
      .clock(clock), .x(rot.mag_v), .y(width_alpha_ff), .p(c1_4));
   egv_mulsat #(.XW(50), .YW(32), .SH(30), .CAPW(34)) u_mul_c2 (
      .clock(clock), .x(rot.mag_u), .y(width_beta_ff), .p(c2_4));

   // squares
   logic [45:0] sq_a, sq_b;
   logic [28:0] a2_5_ff, b2_5_ff;

   always_comb begin
      sq_a = 46'(a4) * 46'(a4);
      sq_b = 46'(b4) * 46'(b4);
   end

   always_ff @(posedge clock) begin
      a2_5_ff <= sq_a[44:16];
      b2_5_ff <= sq_b[44:16];
   end

   // angle terms
   logic [40:0] t1_6, t2_6;

   egv_mulsat #(.XW(35), .YW(23), .SH(16), .CAPW(40)) u_mul_t1 (
      .clock(clock), .x(c1_4), .y(a4), .p(t1_6));
   egv_mulsat #(.XW(35), .YW(23), .SH(16), .CAPW(40)) u_mul_t2 (
      .clock(clock), .x(c2_4), .y(b4), .p(t2_6));

   // exponent sum and asymmetry terms
   logic [60:0] pa, pb;
   logic [29:0] s6_ff;
   logic [35:0] ta6_ff, tb6_ff;

   always_comb begin
      pa = 61'(a2_5_ff) * 61'(asym_plus_gain_ff);
      pb = 61'(b2_5_ff) * 61'(asym_minus_gain_ff);
   end

   always_ff @(posedge clock) begin
      s6_ff  <= 30'(a2_5_ff) + 30'(b2_5_ff);
      ta6_ff <= pa[60:25];
      tb6_ff <= pb[60:25];
   end

   // gaussian factor
   logic [30:0] e11;

   egv_expo #(.N(EXP_TABLE_ENTRIES)) u_expo (
      .clock (clock),
      .s     (s6_ff),
      .e     (e11)
   );

   // signed differences as sign and magnitude
   logic               sgn6;
   logic signed [36:0] dasym;
   logic signed [41:0] dang;
   logic [35:0]        dasym_mag7_ff;
   logic [40:0]        dang_mag7_ff;
   logic               dasym_neg7_ff, dang_neg7_ff;

   egv_delay #(.W(1), .D(4)) u_dly_sgn (.clock(clock), .din(rot.sign_x), .dout(sgn6));

   always_comb begin
      dasym = $signed({1'b0, ta6_ff}) - $signed({1'b0, tb6_ff});
      dang  = $signed({1'b0, t1_6}) - $signed({1'b0, t2_6});
   end

   always_ff @(posedge clock) begin
      dasym_mag7_ff <= dasym[36] ? 36'(-dasym) : 36'(dasym);
      dasym_neg7_ff <= dasym[36];
      dang_mag7_ff  <= dang[41] ? 41'(-dang) : 41'(dang);
      dang_neg7_ff  <= sgn6 ^ dang[41];
   end

   // alignment of side data
   logic [29:0] s13;
   logic [35:0] dasym13;
   logic [40:0] dang13;
   logic        dasym_neg17, dang_neg17;
   logic        enz17;
   logic [16:0] ef17;

   egv_delay #(.W(30), .D(7)) u_dly_s (.clock(clock), .din(s6_ff), .dout(s13));
   egv_delay #(.W(77), .D(6)) u_dly_mag (
      .clock(clock), .din({dasym_mag7_ff, dang_mag7_ff}), .dout({dasym13, dang13}));
   egv_delay #(.W(2), .D(10)) u_dly_neg (
      .clock(clock), .din({dasym_neg7_ff, dang_neg7_ff}), .dout({dasym_neg17, dang_neg17}));
   egv_delay #(.W(18), .D(6)) u_dly_e (
      .clock(clock), .din({e11 != 31'd0, e11[30:14]}), .dout({enz17, ef17}));

   // visibility amplitude
   logic [31:0] flux_mag, g_mag;
   logic [31:0] v13, v17;

   always_comb begin
      flux_mag = flux_param_ff[31] ? 32'(-flux_param_ff) : 32'(flux_param_ff);
      g_mag    = size_gain_ff[31] ? 32'(-size_gain_ff) : 32'(size_gain_ff);
   end

   egv_mulsat #(.XW(32), .YW(31), .SH(30), .CAPW(31)) u_mul_v (
      .clock(clock), .x(flux_mag), .y(e11), .p(v13));
   egv_delay #(.W(32), .D(4)) u_dly_v (.clock(clock), .din(v13), .dout(v17));

   // derivative magnitudes
   logic [40:0] m1_15, masym15, mang15, msize17, masym17, mang17;

   egv_mulsat #(.XW(32), .YW(30), .SH(16), .CAPW(40)) u_mul_m1 (
      .clock(clock), .x(v13), .y(s13), .p(m1_15));
   egv_mulsat #(.XW(36), .YW(32), .SH(16), .CAPW(40)) u_mul_asym (
      .clock(clock), .x(dasym13), .y(v13), .p(masym15));
   egv_mulsat #(.XW(41), .YW(32), .SH(16), .CAPW(40)) u_mul_ang (
      .clock(clock), .x(dang13), .y(v13), .p(mang15));
   egv_mulsat #(.XW(41), .YW(32), .SH(16), .CAPW(40)) u_mul_size (
      .clock(clock), .x(m1_15), .y(g_mag), .p(msize17));
   egv_delay #(.W(82), .D(2)) u_dly_m (
      .clock(clock), .din({masym15, mang15}), .dout({masym17, mang17}));

   // output register, all zero when the gaussian vanished
   logic        g_pos;
   logic [31:0] vis_ff, dflux_ff, dsize_ff, dasym_ff, dangle_ff;

   assign g_pos = !size_gain_ff[31] && (size_gain_ff != 32'sd0);

   always_ff @(posedge clock) begin
      if (enz17) begin
         vis_ff    <= pack_q(1'b0, 41'(v17));
         dflux_ff  <= pack_q(flux_param_ff[31], 41'(ef17));
         dsize_ff  <= pack_q(g_pos, msize17);
         dasym_ff  <= pack_q(dasym_neg17, masym17);
         dangle_ff <= pack_q(dang_neg17, mang17);
      end else begin
         vis_ff    <= '0;
         dflux_ff  <= '0;
         dsize_ff  <= '0;
         dasym_ff  <= '0;
         dangle_ff <= '0;
      end
   end

   assign rsp_strobe   = vld_ff[LATENCY-1];
   assign rsp_vis_real = $signed(vis_ff);
   assign rsp_d_flux   = $signed(dflux_ff);
   assign rsp_d_size   = $signed(dsize_ff);
   assign rsp_d_asym   = $signed(dasym_ff);
   assign rsp_d_angle  = $signed(dangle_ff);

   // checks
   a_strobe_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without an item accepted at the pipeline depth");

   a_vis_nonneg : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !rsp_vis_real[31])
      else $error("negative visibility");

   a_zero_vis : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_vis_real == 32'sd0) |->
         (rsp_d_size == 32'sd0 && rsp_d_asym == 32'sd0 && rsp_d_angle == 32'sd0))
      else $error("derivative nonzero with zero visibility");

endmodule

FILE: src/egv_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egv_delay
// fixed-length register line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module egv_delay #(
   parameter int W = 8,
   parameter int D = 2
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] line_ff [0:D-1];

   // shift by one stage per cycle
   always_ff @(posedge clock) begin
      line_ff[0] <= din;
      for (int k = 1; k < D; k++) begin
         line_ff[k] <= line_ff[k-1];
      end
   end

   assign dout = line_ff[D-1];

endmodule

FILE: src/egv_mulsat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egv_mulsat
// two-stage unsigned multiply, right shift and saturate to a power of two
// ----------------------------------------------------------------------------
module egv_mulsat #(
   parameter int XW   = 32,
   parameter int YW   = 32,
   parameter int SH   = 16,
   parameter int CAPW = 40
) (
   input  logic          clock,
   input  logic [XW-1:0] x,
   input  logic [YW-1:0] y,
   output logic [CAPW:0] p
);

   localparam int XL = XW / 2;
   localparam int XH = XW - XL;
   localparam int PW = XW + YW;
   localparam logic [PW-1:0] CAP = PW'(1) << CAPW;

   logic [XL+YW-1:0] lo_ff;
   logic [XH+YW-1:0] hi_ff;
   logic [PW-1:0]    full;
   logic [PW-1:0]    shr;
   logic [CAPW:0]    p_ff;

   // partial products of the two halves of x
   always_ff @(posedge clock) begin
      lo_ff <= (XL+YW)'(x[XL-1:0]) * (XL+YW)'(y);
      hi_ff <= (XH+YW)'(x[XW-1:XL]) * (XH+YW)'(y);
   end

   // recombine, scale and clamp
   always_comb begin
      full = (PW'(hi_ff) << XL) + PW'(lo_ff);
      shr  = full >> SH;
   end

   always_ff @(posedge clock) begin
      p_ff <= (shr > CAP) ? CAP[CAPW:0] : shr[CAPW:0];
   end

   assign p = p_ff;

endmodule

FILE: src/egv_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egv_rotate
// rotates the baseline by the position angle, returns magnitudes and the sign product
// ----------------------------------------------------------------------------
module egv_rotate
   import egv_pkg::*;
(
   input  logic               clock,
   input  logic signed [31:0] u,
   input  logic signed [31:0] v,
   input  logic signed [31:0] c,
   input  logic signed [31:0] s,
   output rot_type            rot
);

   logic signed [63:0] uc_ff, vs_ff, vc_ff, us_ff;
   logic signed [50:0] ru, rv;
   rot_type            rot_ff;

   // four signed products
   always_ff @(posedge clock) begin
      uc_ff <= 64'(u) * 64'(c);
      vs_ff <= 64'(v) * 64'(s);
      vc_ff <= 64'(v) * 64'(c);
      us_ff <= 64'(u) * 64'(s);
   end

   // floor shift by 14 and combine
   always_comb begin
      ru = -($signed({uc_ff[63], uc_ff[63:14]}) + $signed({vs_ff[63], vs_ff[63:14]}));
      rv = $signed({vc_ff[63], vc_ff[63:14]}) - $signed({us_ff[63], us_ff[63:14]});
   end

   always_ff @(posedge clock) begin
      rot_ff.mag_u  <= ru[50] ? 50'(-ru) : 50'(ru);
      rot_ff.mag_v  <= rv[50] ? 50'(-rv) : 50'(rv);
      rot_ff.sign_x <= ru[50] ^ rv[50];
   end

   assign rot = rot_ff;

endmodule

FILE: src/egv_expo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egv_expo
// gaussian factor 2^-y from an interpolated exp2 table and a right shift
// ----------------------------------------------------------------------------
module egv_expo
   import egv_pkg::*;
#(
   parameter int N = 256
) (
   input  logic        clock,
   input  logic [29:0] s,
   output logic [30:0] e
);

   localparam int TW  = $clog2(N + 1);
   localparam int IW  = $clog2(N);
   localparam int IXW = 16 + TW;

   logic [30:0] tab [0:N];

   // exp2 table 2^(-k/N) in q.30, series of exp(-k*ln2/N) in q.32
   for (genvar k = 0; k <= N; k++) begin : g_tab
      localparam logic [63:0] Z   = (64'(k) * LN2_Q32) / N;
      localparam logic [63:0] T0  = 64'd1 << 32;
      localparam logic [63:0] T1  = ((T0 * Z) >> 32) / 1;
      localparam logic [63:0] T2  = ((T1 * Z) >> 32) / 2;
      localparam logic [63:0] T3  = ((T2 * Z) >> 32) / 3;
      localparam logic [63:0] T4  = ((T3 * Z) >> 32) / 4;
      localparam logic [63:0] T5  = ((T4 * Z) >> 32) / 5;
      localparam logic [63:0] T6  = ((T5 * Z) >> 32) / 6;
      localparam logic [63:0] T7  = ((T6 * Z) >> 32) / 7;
      localparam logic [63:0] T8  = ((T7 * Z) >> 32) / 8;
      localparam logic [63:0] T9  = ((T8 * Z) >> 32) / 9;
      localparam logic [63:0] T10 = ((T9 * Z) >> 32) / 10;
      localparam logic [63:0] T11 = ((T10 * Z) >> 32) / 11;
      localparam logic [63:0] T12 = ((T11 * Z) >> 32) / 12;
      localparam logic [63:0] T13 = ((T12 * Z) >> 32) / 13;
      localparam logic [63:0] T14 = ((T13 * Z) >> 32) / 14;
      localparam longint SUM = longint'(T0) - longint'(T1) + longint'(T2)
                             - longint'(T3) + longint'(T4) - longint'(T5)
                             + longint'(T6) - longint'(T7) + longint'(T8)
                             - longint'(T9) + longint'(T10) - longint'(T11)
                             + longint'(T12) - longint'(T13) + longint'(T14);
      localparam longint SUMC = (SUM < 0) ? 64'sd0 : SUM;
      localparam logic [63:0] ENTRY = (64'(SUMC) + 64'd2) >> 2;
      assign tab[k] = ENTRY[30:0];
   end

   logic [55:0]        yprod;
   logic [24:0]        y7_ff;
   logic               ok7_ff, ok8_ff, ok9_ff, ok10_ff;
   logic [IXW-1:0]     idx;
   logic [8:0]         n8_ff, n9_ff, n10_ff;
   logic [IW-1:0]      i8_ff;
   logic [15:0]        rem8_ff, rem9_ff;
   logic [30:0]        lo9_ff, hi9_ff, lo10_ff;
   logic signed [31:0] tdiff;
   logic signed [16:0] trem;
   logic signed [48:0] prod10_ff;
   logic signed [32:0] corr, val;
   logic [30:0]        e_ff;

   // base-2 exponent and range check
   assign yprod = 56'(s[24:0]) * 56'(LOG2E_Q30);

   always_ff @(posedge clock) begin
      ok7_ff <= (s <= EXPO_LIMIT);
      y7_ff  <= yprod[55:31];
   end

   // table position of the fraction
   assign idx = IXW'(y7_ff[15:0]) * IXW'(N);

   always_ff @(posedge clock) begin
      ok8_ff  <= ok7_ff;
      n8_ff   <= y7_ff[24:16];
      i8_ff   <= idx[16+IW-1:16];
      rem8_ff <= idx[15:0];
   end

   // table read of both neighbors
   always_ff @(posedge clock) begin
      ok9_ff  <= ok8_ff;
      n9_ff   <= n8_ff;
      rem9_ff <= rem8_ff;
      lo9_ff  <= tab[TW'(i8_ff)];
      hi9_ff  <= tab[TW'(i8_ff) + TW'(1)];
   end

   // interpolation product
   always_comb begin
      tdiff = $signed({1'b0, lo9_ff}) - $signed({1'b0, hi9_ff});
      trem  = $signed({1'b0, rem9_ff});
   end

   always_ff @(posedge clock) begin
      ok10_ff   <= ok9_ff;
      n10_ff    <= n9_ff;
      lo10_ff   <= lo9_ff;
      prod10_ff <= 49'(tdiff) * 49'(trem);
   end

   // interpolated value, clamp and shift by the integer part
   always_comb begin
      corr = $signed(prod10_ff[48:16]);
      val  = $signed({2'b00, lo10_ff}) - corr;
   end

   always_ff @(posedge clock) begin
      if (!ok10_ff || n10_ff >= 9'd31 || val[32]) begin
         e_ff <= '0;
      end else begin
         e_ff <= val[30:0] >> n10_ff;
      end
   end

   assign e = e_ff;

endmodule

FILE: dv/elliptical_gaussian_visibility_grad_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptical_gaussian_visibility_grad_tb
// self-checking bench for the elliptical gaussian visibility pipeline: drives
// baselines, random ones in bursts, predicts the visibility and its derivatives
// in fixed point, and compares every strobed result with the oldest prediction
// ----------------------------------------------------------------------------
module elliptical_gaussian_visibility_grad_tb;
   import egv_pkg::*;

   localparam int NTAB = 256;
   localparam int IDLE_LIMIT = 5000;
   localparam longint unsigned CAP_AB = 64'd1 << 22;
   localparam longint unsigned CAP_C = 64'd1 << 34;
   localparam longint unsigned CAP_W = 64'd1 << 40;

   typedef struct packed {
      logic [31:0] vis_real;
      logic [31:0] d_flux;
      logic [31:0] d_size;
      logic [31:0] d_asym;
      logic [31:0] d_angle;
   } vis_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_baseline_u = '0;
   logic signed [31:0] req_baseline_v = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_vis_real, rsp_d_flux, rsp_d_size, rsp_d_asym, rsp_d_angle;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_write_data = '0;

   // register shadow and exp2 table of the predictor
   logic [31:0] reg_shadow [8];
   longint unsigned exp2_q30 [NTAB + 1];
   vis_res_type vis_expect_q [$];
   int fail_count = 0;
   int idle_cycles = 0;

   elliptical_gaussian_visibility_grad #(.EXP_TABLE_ENTRIES(NTAB)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_baseline_u(req_baseline_u), .req_baseline_v(req_baseline_v),
      .rsp_strobe(rsp_strobe), .rsp_vis_real(rsp_vis_real), .rsp_d_flux(rsp_d_flux),
      .rsp_d_size(rsp_d_size), .rsp_d_asym(rsp_d_asym), .rsp_d_angle(rsp_d_angle),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned umul_cap(longint unsigned x, longint unsigned y,
                                                int sh, longint unsigned cap);
      longint unsigned p;
      if (y != 0 && x > 64'hFFFF_FFFF_FFFF_FFFF / y) return cap;
      p = (x * y) >> sh;
      return (p > cap) ? cap : p;
   endfunction

   function automatic longint unsigned mag(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic [31:0] sat_pack(bit neg, longint unsigned m);
      if (neg) begin
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         return 32'(64'd0 - m);
      end
      return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(m);
   endfunction

   task automatic build_exp2_table();
      longint unsigned z, term;
      longint sum;
      for (int k = 0; k <= NTAB; k++) begin
         z = (64'(k) * LN2_Q32) / NTAB;
         term = 64'd1 << 32;
         sum = longint'(term);
         for (int i = 1; i <= 14; i++) begin
            term = ((term * z) >> 32) / i;
            sum = (i % 2) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         exp2_q30[k] = (64'(sum) + 2) >> 2;
      end
   endtask

   function automatic vis_res_type predict_visibility(logic [31:0] bu, logic [31:0] bv);
      vis_res_type r;
      longint u, v, c, sn, ru, rv, diff, g, lo, val, rem;
      longint unsigned mu, mv, a, b, a2, b2, s, e, vv, m, ta, tb, c1, c2, t1, t2;
      longint unsigned y, n, idx, i;
      r = '0;
      e = 0;
      u = longint'($signed(bu));
      v = longint'($signed(bv));
      c = longint'($signed(reg_shadow[CSR_COS_ANGLE]));
      sn = longint'($signed(reg_shadow[CSR_SIN_ANGLE]));
      // rotate baseline by the position angle
      ru = -(((u * c) >>> 14) + ((v * sn) >>> 14));
      rv = ((v * c) >>> 14) - ((u * sn) >>> 14);
      mu = mag(ru);
      mv = mag(rv);
      a = umul_cap(mu, 64'(reg_shadow[CSR_WIDTH_ALPHA]), 30, CAP_AB);
      b = umul_cap(mv, 64'(reg_shadow[CSR_WIDTH_BETA]), 30, CAP_AB);
      a2 = (a * a) >> 16;
      b2 = (b * b) >> 16;
      s = a2 + b2;
      // gaussian by table interpolation and shift, zero past the deep limit
      if (s <= 64'(EXPO_LIMIT)) begin
         y = (s * 64'(LOG2E_Q30)) >> 31;
         n = y >> 16;
         idx = (y & 64'hFFFF) * NTAB;
         i = idx >> 16;
         rem = longint'(idx & 64'hFFFF);
         lo = longint'(exp2_q30[i]);
         val = lo - (((lo - longint'(exp2_q30[i + 1])) * rem) >>> 16);
         if (val < 0) val = 0;
         if (n < 31) e = 64'(val) >> n;
      end
      if (e == 0) return r;
      vv = umul_cap(mag(longint'($signed(reg_shadow[CSR_FLUX_PARAM]))), e, 30, 64'd1 << 31);
      r.vis_real = sat_pack(1'b0, vv);
      r.d_flux = sat_pack(reg_shadow[CSR_FLUX_PARAM][31], e >> 14);
      g = longint'($signed(reg_shadow[CSR_SIZE_GAIN]));
      m = umul_cap(umul_cap(vv, s, 16, CAP_W), mag(g), 16, CAP_W);
      r.d_size = sat_pack(g > 0, m);
      ta = (a2 * 64'(reg_shadow[CSR_ASYM_PLUS_GAIN])) >> 25;
      tb = (b2 * 64'(reg_shadow[CSR_ASYM_MINUS_GAIN])) >> 25;
      diff = longint'(ta) - longint'(tb);
      r.d_asym = sat_pack(diff < 0, umul_cap(vv, mag(diff), 16, CAP_W));
      c1 = umul_cap(mv, 64'(reg_shadow[CSR_WIDTH_ALPHA]), 30, CAP_C);
      c2 = umul_cap(mu, 64'(reg_shadow[CSR_WIDTH_BETA]), 30, CAP_C);
      t1 = umul_cap(a, c1, 16, CAP_W);
      t2 = umul_cap(c2, b, 16, CAP_W);
      diff = longint'(t1) - longint'(t2);
      r.d_angle = sat_pack(((ru < 0) != (rv < 0)) != (diff < 0),
                           umul_cap(vv, mag(diff), 16, CAP_W));
      return r;
   endfunction

   // ---------------- result checking ----------------
   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      vis_res_type exp_r;
      if (!reset && rsp_strobe) begin
         if (vis_expect_q.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            exp_r = vis_expect_q.pop_front();
            check_field("vis_real", exp_r.vis_real, rsp_vis_real);
            check_field("d_flux", exp_r.d_flux, rsp_d_flux);
            check_field("d_size", exp_r.d_size, rsp_d_size);
            check_field("d_asym", exp_r.d_asym, rsp_d_asym);
            check_field("d_angle", exp_r.d_angle, rsp_d_angle);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_item(logic [31:0] bu, logic [31:0] bv);
      start <= 1'b1;
      req_baseline_u <= bu;
      req_baseline_v <= bv;
      do @(posedge clock); while (busy);
      vis_expect_q.push_back(predict_visibility(bu, bv));
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait until all results are back and the pipe is empty
   task automatic drain();
      start <= 1'b0;
      while (vis_expect_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      reg_shadow[idx] = data;
   endtask

   function automatic logic [31:0] rand_coord();
      logic [31:0] x;
      if ($urandom_range(0, 3) == 0) return $urandom;
      x = $urandom >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? -x : x;
   endfunction

   function automatic logic [31:0] rand_unit();
      logic [31:0] x;
      if ($urandom_range(0, 7) == 0) return $urandom;
      x = $urandom_range(0, 32'h4000_0000);
      return $urandom_range(0, 1) ? -x : x;
   endfunction

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      send_item(32'd0, 32'd0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'h0000_0001);
      drain();
   endtask

   task automatic test_directed();
      csr_write(CSR_FLUX_PARAM, 32'hFFFE_0000);
      csr_write(CSR_WIDTH_ALPHA, 32'h0004_0000);
      csr_write(CSR_WIDTH_BETA, 32'h0002_0000);
      csr_write(CSR_COS_ANGLE, 32'h4000_0000);
      csr_write(CSR_SIN_ANGLE, 32'h0000_0000);
      csr_write(CSR_SIZE_GAIN, 32'h0001_8000);
      csr_write(CSR_ASYM_PLUS_GAIN, 32'h0080_0000);
      csr_write(CSR_ASYM_MINUS_GAIN, 32'h0200_0000);
      send_item(32'd0, 32'd0);
      send_item(32'd40960, 32'd0);
      send_item(-32'd40960, 32'd81920);
      send_item(32'd102400, 32'd0);
      // past the deep exponent limit
      send_item(32'd118784, 32'd0);
      send_item(32'd600000, 32'd600000);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h8000_0000);
      drain();
      // quarter turn, oversized gains
      csr_write(CSR_COS_ANGLE, 32'h0000_0000);
      csr_write(CSR_SIN_ANGLE, 32'hC000_0000);
      csr_write(CSR_FLUX_PARAM, 32'h7FFF_FFFF);
      csr_write(CSR_SIZE_GAIN, 32'h8000_0000);
      csr_write(CSR_ASYM_PLUS_GAIN, 32'hFFFF_FFFF);
      send_item(32'd20480, -32'd20480);
      send_item(32'd1, 32'd2);
      send_item(-32'd70000, 32'd3000);
      send_item(32'd0, 32'd1000);
      drain();
   endtask

   task automatic test_extreme_registers(bit high_side);
      if (high_side) begin
         csr_write(CSR_FLUX_PARAM, 32'h7FFF_FFFF);
         csr_write(CSR_WIDTH_ALPHA, 32'hFFFF_FFFF);
         csr_write(CSR_WIDTH_BETA, 32'hFFFF_FFFF);
         csr_write(CSR_COS_ANGLE, 32'h4000_0000);
         csr_write(CSR_SIN_ANGLE, 32'h4000_0000);
         csr_write(CSR_SIZE_GAIN, 32'h7FFF_FFFF);
         csr_write(CSR_ASYM_PLUS_GAIN, 32'hFFFF_FFFF);
         csr_write(CSR_ASYM_MINUS_GAIN, 32'hFFFF_FFFF);
      end else begin
         csr_write(CSR_FLUX_PARAM, 32'h8000_0000);
         csr_write(CSR_WIDTH_ALPHA, 32'h0000_0001);
         csr_write(CSR_WIDTH_BETA, 32'h0000_0000);
         csr_write(CSR_COS_ANGLE, 32'hC000_0000);
         csr_write(CSR_SIN_ANGLE, 32'hC000_0000);
         csr_write(CSR_SIZE_GAIN, 32'h8000_0000);
         csr_write(CSR_ASYM_PLUS_GAIN, 32'h0000_0000);
         csr_write(CSR_ASYM_MINUS_GAIN, 32'h0000_0000);
      end
      for (int k = 0; k < 40; k++) begin
         // even items use small baselines so that huge widths still leave a gaussian
         if (k % 2) send_item(rand_coord(), rand_coord());
         else send_item($urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2);
      end
      drain();
   endtask

   task automatic test_random_phase(int n_items);
      int burst;
      csr_write(CSR_FLUX_PARAM, $urandom);
      csr_write(CSR_WIDTH_ALPHA, $urandom >> $urandom_range(0, 31));
      csr_write(CSR_WIDTH_BETA, $urandom >> $urandom_range(0, 31));
      csr_write(CSR_COS_ANGLE, rand_unit());
      csr_write(CSR_SIN_ANGLE, rand_unit());
      csr_write(CSR_SIZE_GAIN, $urandom);
      csr_write(CSR_ASYM_PLUS_GAIN, $urandom >> $urandom_range(0, 8));
      csr_write(CSR_ASYM_MINUS_GAIN, $urandom >> $urandom_range(0, 8));
      burst = $urandom_range(1, 40);
      for (int k = 0; k < n_items; k++) begin
         send_item(rand_coord(), rand_coord());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
         end
      end
      drain();
   endtask

   initial begin
      for (int k = 0; k < 8; k++) reg_shadow[k] = '0;
      reg_shadow[CSR_FLUX_PARAM] = 32'd65536;
      reg_shadow[CSR_COS_ANGLE] = 32'h4000_0000;
      build_exp2_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_extreme_registers(1'b1);
      test_extreme_registers(1'b0);
      for (int p = 0; p < 9; p++) test_random_phase(200);
      drain();
      if (fail_count == 0 && vis_expect_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/egv_pkg.sv
src/egv_delay.sv
src/egv_mulsat.sv
src/egv_rotate.sv
src/egv_expo.sv
src/elliptical_gaussian_visibility_grad.sv
dv/elliptical_gaussian_visibility_grad_tb.sv
